// File: rtl/core/dbav_pkg.sv
// Shared types, widths and constants of the decimating block-average voltmeter.
// No dependencies; every other file refers to it by scoped names.
package dbav_pkg;

    localparam int CHANNELS  = 4;
    localparam int SAMPLES   = 8;
    localparam int LANES     = 4;

    localparam int RAW_W     = 12;
    localparam int AVG_W     = 12;
    localparam int MV_W      = 16;
    localparam int TICK_W    = 8;
    localparam int MVQ_W     = 24;
    localparam int GAIN_W    = 12;
    localparam int DROP_W    = 12;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam int SUM_W     = RAW_W + $clog2(SAMPLES);
    localparam int CNT_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // reciprocal of SAMPLES scaled by 2^SUM_W; quotient is exact or one low
    localparam int RECIP_W   = SUM_W + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SUM_W) / SAMPLES);
    localparam int FIX_W     = AVG_W + 1 + $clog2(SAMPLES + 1);

    localparam int MUL_A_W   = AVG_W + MVQ_W;
    localparam int MUL_B_W   = MVQ_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MV0_W     = MVQ_W + 2;
    localparam int MV1_W     = MUL_A_W - 16;

    localparam logic [TICK_W-1:0] TICK_DIVIDE_RST = TICK_W'(10);
    localparam logic [MVQ_W-1:0]  MV_PER_LSB_RST  = MVQ_W'(52800);
    localparam logic [GAIN_W-1:0] GAIN_RST        = GAIN_W'(1024);
    localparam logic [DROP_W-1:0] DROP_RST        = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_DIVIDE = 2'd0,
        CFG_MV_PER_LSB  = 2'd1,
        CFG_GAIN        = 2'd2,
        CFG_DROP        = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [TICK_W-1:0]        tick_divide;
        logic [MVQ_W-1:0]         mv_per_lsb_q16;
        logic [GAIN_W-1:0]        divider_gain_q8;
        logic signed [DROP_W-1:0] drop_offset_mv;
    } t_cfg;

    typedef struct packed {
        logic [RAW_W-1:0] raw_ch0;
        logic [RAW_W-1:0] raw_ch1;
        logic [RAW_W-1:0] raw_ch2;
        logic [RAW_W-1:0] raw_ch3;
    } t_in_item;

    typedef struct packed {
        logic [AVG_W-1:0] avg_ch0;
        logic [AVG_W-1:0] avg_ch1;
        logic [AVG_W-1:0] avg_ch2;
        logic [AVG_W-1:0] avg_ch3;
        logic [MV_W-1:0]  mv_ch0;
        logic [MV_W-1:0]  mv_ch1;
        logic [MV_W-1:0]  mv_ch2;
        logic [MV_W-1:0]  mv_ch3;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_IDLE = 3'd0,
        OP_DIV  = 3'd1,
        OP_FIX  = 3'd2,
        OP_MV   = 3'd3,
        OP_GAIN = 3'd4,
        OP_SAT  = 3'd5,
        OP_LOAD = 3'd6
    } t_op;

    typedef struct packed {
        logic            take;
        t_op             op;
        logic [CH_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic block_last;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/core/dbav_in_if.sv
// Input channel of the voltmeter: valid/ready plus one tick of raw codes.
// Depends on dbav_pkg for the item type.
interface dbav_in_if;
    logic                valid;
    logic                ready;
    dbav_pkg::t_in_item  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: rtl/core/dbav_out_if.sv
// Result channel of the voltmeter: valid/ready plus averages and millivolts.
// Depends on dbav_pkg for the item type.
interface dbav_out_if;
    logic                valid;
    logic                ready;
    dbav_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: rtl/core/dbav_cfg.sv
// Configuration register bank, written through a plain write port.
// Depends on dbav_pkg.
module dbav_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dbav_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dbav_pkg::CFG_W-1:0]         i_cfg_data,
    output dbav_pkg::t_cfg                     o_cfg
);

    dbav_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_divide     <= dbav_pkg::TICK_DIVIDE_RST;
            r_cfg.mv_per_lsb_q16  <= dbav_pkg::MV_PER_LSB_RST;
            r_cfg.divider_gain_q8 <= dbav_pkg::GAIN_RST;
            r_cfg.drop_offset_mv  <= dbav_pkg::DROP_RST;
        end else if (i_cfg_we) begin
            case (dbav_pkg::t_cfg_idx'(i_cfg_idx))
                dbav_pkg::CFG_TICK_DIVIDE: begin
                    r_cfg.tick_divide <= i_cfg_data[dbav_pkg::TICK_W-1:0];
                end
                dbav_pkg::CFG_MV_PER_LSB: begin
                    r_cfg.mv_per_lsb_q16 <= i_cfg_data[dbav_pkg::MVQ_W-1:0];
                end
                dbav_pkg::CFG_GAIN: begin
                    r_cfg.divider_gain_q8 <= i_cfg_data[dbav_pkg::GAIN_W-1:0];
                end
                dbav_pkg::CFG_DROP: begin
                    r_cfg.drop_offset_mv <= i_cfg_data[dbav_pkg::DROP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/dbav_ctrl.sv
// Sequencer: takes ticks while idle, then walks the channels through
// divide, correct, scale and saturate steps on the shared multiplier. Uses dbav_pkg.
module dbav_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dbav_pkg::t_stat   i_stat,
    output logic              o_in_ready,
    output dbav_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_FIX  = 7'b0000100,
        ST_MV   = 7'b0001000,
        ST_GAIN = 7'b0010000,
        ST_SAT  = 7'b0100000,
        ST_LOAD = 7'b1000000
    } t_state;

    t_state                      r_state, n_state;
    logic [dbav_pkg::CH_W-1:0]   r_ch, n_ch;
    logic                        take;
    logic                        ch_last;

    assign take    = i_in_valid && (r_state == ST_IDLE);
    assign ch_last = (r_ch == dbav_pkg::CH_W'(dbav_pkg::CHANNELS - 1));

    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        o_cmd.take = take;
        o_cmd.ch   = r_ch;
        o_cmd.op   = dbav_pkg::OP_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (take && i_stat.block_last) begin
                    n_state = ST_DIV;
                    n_ch    = '0;
                end
            end
            ST_DIV: begin
                o_cmd.op = dbav_pkg::OP_DIV;
                n_state  = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.op = dbav_pkg::OP_FIX;
                n_state  = ST_MV;
            end
            ST_MV: begin
                o_cmd.op = dbav_pkg::OP_MV;
                n_state  = (r_ch == '0) ? ST_GAIN : ST_SAT;
            end
            ST_GAIN: begin
                o_cmd.op = dbav_pkg::OP_GAIN;
                n_state  = ST_SAT;
            end
            ST_SAT: begin
                o_cmd.op = dbav_pkg::OP_SAT;
                if (ch_last) begin
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_DIV;
                    n_ch    = r_ch + 1'b1;
                end
            end
            ST_LOAD: begin
                // hold until the result register is free
                if (i_stat.out_free) begin
                    o_cmd.op = dbav_pkg::OP_LOAD;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// File: rtl/core/dbav_dpath.sv
// Datapath: tick divider, per-channel sums, shared multiplier, reciprocal
// divide with correction, saturation and the result register. Uses dbav_pkg.
module dbav_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dbav_pkg::t_cfg       i_cfg,
    input  dbav_pkg::t_in_item   i_in_item,
    input  dbav_pkg::t_cmd       i_cmd,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output dbav_pkg::t_out_item  o_out_item,
    output dbav_pkg::t_stat      o_stat
);

    localparam int SUM_W   = dbav_pkg::SUM_W;
    localparam int AVG_W   = dbav_pkg::AVG_W;
    localparam int MV_W    = dbav_pkg::MV_W;
    localparam int FIX_W   = dbav_pkg::FIX_W;
    localparam int MUL_A_W = dbav_pkg::MUL_A_W;
    localparam int MUL_B_W = dbav_pkg::MUL_B_W;
    localparam int PROD_W  = dbav_pkg::PROD_W;
    localparam int MV0_W   = dbav_pkg::MV0_W;
    localparam int MV1_W   = dbav_pkg::MV1_W;
    localparam int DROP_W  = dbav_pkg::DROP_W;
    localparam int MVQ_W   = dbav_pkg::MVQ_W;

    logic [dbav_pkg::TICK_W-1:0] r_tick;
    logic [dbav_pkg::CNT_W-1:0]  r_reading;
    logic [SUM_W-1:0]            r_sum     [dbav_pkg::CHANNELS];
    logic [PROD_W-1:0]           r_prod;
    logic [AVG_W-1:0]            r_avg;
    logic [AVG_W-1:0]            r_res_avg [dbav_pkg::CHANNELS];
    logic [MV_W-1:0]             r_res_mv  [dbav_pkg::CHANNELS];
    logic                        r_out_valid;
    dbav_pkg::t_out_item         r_out_item;

    logic [dbav_pkg::RAW_W-1:0]  raw       [dbav_pkg::LANES];
    logic [AVG_W-1:0]            load_avg  [dbav_pkg::LANES];
    logic [MV_W-1:0]             load_mv   [dbav_pkg::LANES];
    logic [dbav_pkg::TICK_W-1:0] n_tick;
    logic                        hit;
    logic                        block_last;
    logic                        out_free;
    logic [SUM_W-1:0]            sum_sel;
    logic [MUL_A_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic [PROD_W-1:0]           mul_p;
    logic [AVG_W-1:0]            q_est;
    logic [FIX_W-1:0]            q_back;
    logic [AVG_W-1:0]            avg_fix;
    logic [MVQ_W-1:0]            p0;
    logic signed [MV0_W-1:0]     mv0_sum;
    logic [MV1_W-1:0]            p1;
    logic [MV_W-1:0]             mv_sat;

    assign raw[0] = i_in_item.raw_ch0;
    assign raw[1] = i_in_item.raw_ch1;
    assign raw[2] = i_in_item.raw_ch2;
    assign raw[3] = i_in_item.raw_ch3;

    assign n_tick     = r_tick + 1'b1;
    assign hit        = (n_tick == i_cfg.tick_divide);
    assign block_last = hit && (r_reading == dbav_pkg::CNT_W'(dbav_pkg::SAMPLES - 1));
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_stat.block_last = block_last;
    assign o_stat.out_free   = out_free;

    assign sum_sel = r_sum[i_cmd.ch];

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            dbav_pkg::OP_DIV: begin
                mul_a = MUL_A_W'(sum_sel);
                mul_b = MUL_B_W'(dbav_pkg::RECIP);
            end
            dbav_pkg::OP_MV: begin
                mul_a = MUL_A_W'(r_avg);
                mul_b = i_cfg.mv_per_lsb_q16;
            end
            dbav_pkg::OP_GAIN: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = MUL_B_W'(i_cfg.divider_gain_q8);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // estimate is the true quotient or one below it
    assign q_est   = r_prod[SUM_W +: AVG_W];
    assign q_back  = FIX_W'({1'b0, q_est} + 1'b1) * FIX_W'(dbav_pkg::SAMPLES);
    assign avg_fix = (FIX_W'(sum_sel) >= q_back) ? q_est + 1'b1 : q_est;

    // battery: product of three factors, Q24 down, then signed offset
    assign p0      = r_prod[24 +: MVQ_W];
    assign mv0_sum = $signed({2'b00, p0})
                   + $signed({{(MV0_W - DROP_W){i_cfg.drop_offset_mv[DROP_W-1]}},
                              i_cfg.drop_offset_mv});
    assign p1      = r_prod[16 +: MV1_W];

    always_comb begin
        if (i_cmd.ch == '0) begin
            if (mv0_sum < 0) begin
                mv_sat = '0;
            end else if (mv0_sum > $signed(MV0_W'(65535))) begin
                mv_sat = '1;
            end else begin
                mv_sat = mv0_sum[MV_W-1:0];
            end
        end else begin
            mv_sat = (|p1[MV1_W-1:MV_W]) ? '1 : p1[MV_W-1:0];
        end
    end

    always_comb begin
        for (int c = 0; c < dbav_pkg::LANES; c++) begin
            if (c < dbav_pkg::CHANNELS) begin
                load_avg[c] = r_res_avg[dbav_pkg::CH_W'(c)];
                load_mv[c]  = r_res_mv[dbav_pkg::CH_W'(c)];
            end else begin
                load_avg[c] = '0;
                load_mv[c]  = '0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_reading   <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < dbav_pkg::CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (i_cmd.take) begin
                r_tick <= hit ? '0 : n_tick;
                if (hit) begin
                    r_reading <= block_last ? '0 : r_reading + 1'b1;
                    for (int c = 0; c < dbav_pkg::CHANNELS; c++) begin
                        r_sum[c] <= r_sum[c] + SUM_W'(raw[c]);
                    end
                end
            end
            if (i_cmd.op == dbav_pkg::OP_LOAD) begin
                for (int c = 0; c < dbav_pkg::CHANNELS; c++) begin
                    r_sum[c] <= '0;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            dbav_pkg::OP_DIV, dbav_pkg::OP_MV, dbav_pkg::OP_GAIN: begin
                r_prod <= mul_p;
            end
            dbav_pkg::OP_FIX: begin
                r_avg               <= avg_fix;
                r_res_avg[i_cmd.ch] <= avg_fix;
            end
            dbav_pkg::OP_SAT: begin
                r_res_mv[i_cmd.ch] <= mv_sat;
            end
            dbav_pkg::OP_LOAD: begin
                r_out_item.avg_ch0 <= load_avg[0];
                r_out_item.avg_ch1 <= load_avg[1];
                r_out_item.avg_ch2 <= load_avg[2];
                r_out_item.avg_ch3 <= load_avg[3];
                r_out_item.mv_ch0  <= load_mv[0];
                r_out_item.mv_ch1  <= load_mv[1];
                r_out_item.mv_ch2  <= load_mv[2];
                r_out_item.mv_ch3  <= load_mv[3];
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: rtl/core/decimating_block_average_voltmeter_unit.sv
// Decimating block-average voltmeter for four ADC channels.
// Input channel i_in: one transfer per timer tick with the latest raw code of
// each channel. Every tick_divide ticks (256 when it is zero) one reading per
// channel goes into a running sum; the tick that completes SAMPLES readings
// produces one transfer on o_res with the truncated averages and millivolts.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data, to be written only while idle;
// the block does not enforce this. A tick that completes no block is simply
// taken while the sequencer idles; the completing tick starts a 4-step pass
// per channel (5 for the battery channel) through the one shared multiplier,
// then the output register is loaded and o_res.valid rises. i_in.ready is low during that pass.
// The result sits in an output register: further ticks are taken while it
// waits, and if o_res is stalled when the next block finishes, the sequencer
// holds that block until the register frees up.
// Reset (synchronous, active low) clears the tick and reading counters, the
// sums and the output valid, and loads the register defaults.
// Depends on dbav_pkg, dbav_in_if, dbav_out_if, dbav_cfg, dbav_ctrl, dbav_dpath.
module decimating_block_average_voltmeter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dbav_in_if.sink                         i_in,
    dbav_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [dbav_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dbav_pkg::CFG_W-1:0]      i_cfg_data
);

    dbav_pkg::t_cfg      cfg;
    dbav_pkg::t_cmd      cmd;
    dbav_pkg::t_stat     stat;
    dbav_pkg::t_out_item out_item;
    logic                in_ready;
    logic                out_valid;

    dbav_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dbav_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    dbav_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_item   (i_in.item),
        .i_cmd       (cmd),
        .i_out_ready (o_res.ready),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .o_stat      (stat)
    );

    assign i_in.ready  = in_ready;
    assign o_res.valid = out_valid;
    assign o_res.item  = out_item;

    // ticks are only taken while no block is being computed
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (cmd.op == dbav_pkg::OP_IDLE))
        else $error("tick taken during block computation");

    // a held result is never overwritten
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == dbav_pkg::OP_LOAD) |-> (!o_res.valid || o_res.ready))
        else $error("result register loaded while still held");

    // a result only appears after a load command
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(cmd.op == dbav_pkg::OP_LOAD))
        else $error("result valid without load");

    // the block computation starts right after the completing tick
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && stat.block_last) |=>
            (cmd.op == dbav_pkg::OP_DIV && !i_in.ready))
        else $error("completing tick did not start computation");

endmodule
